>>> rtl/core/tsv_pkg.sv
// Package for the transfer segment validator: field widths, message and
// status codes, and the classified entry that travels from front to back.
// No dependencies.
`default_nettype none
package tsv_pkg;

	localparam int TYPE_W   = 8;
	localparam int FLAGS_W  = 8;
	localparam int ID_W     = 64;
	localparam int SEGLEN_W = 64;
	localparam int STATUS_W = 4;
	localparam int TOTAL_W  = 29;   // running byte total and offsets
	localparam int LEN_W    = 25;   // a length that passed the segment limit
	localparam int MRU_W    = 25;

	localparam logic [MRU_W-1:0] MRU_RESET = MRU_W'(65536);

	// message type byte
	localparam logic [TYPE_W-1:0] MSG_DATA      = 8'd1;
	localparam logic [TYPE_W-1:0] MSG_KEEPALIVE = 8'd4;
	localparam logic [TYPE_W-1:0] MSG_TERMINATE = 8'd5;

	// segment flag bits
	localparam int FLAG_END_BIT   = 0;
	localparam int FLAG_START_BIT = 1;

	// queue depth between front and back
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		CLS_DATA,
		CLS_KEEPALIVE,
		CLS_TERMINATE,
		CLS_BAD
	} msg_class_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED   = 4'd0,
		ST_KEEPALIVE  = 4'd1,
		ST_COMPLETE   = 4'd2,
		ST_BAD_TYPE   = 4'd3,
		ST_NO_START   = 4'd4,
		ST_EXTRA_START = 4'd5,
		ST_ID_MISMATCH = 4'd6,
		ST_SEG_LONG   = 4'd7,
		ST_TOTAL_LONG = 4'd8,
		ST_TERMINATED = 4'd9,
		ST_NOT_CONN   = 4'd10
	} status_t;

	// one classified header as held in the queue
	typedef struct packed {
		msg_class_t        cls;
		logic              start;
		logic              fin;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic              gt_seg;   // length above the segment limit
		logic              gt_mru;   // length above the negotiated MRU
	} entry_t;

endpackage
`default_nettype wire

>>> rtl/core/tsv_if.sv
// Handshake channels of the validator: header input and result output.
// Depends on tsv_pkg.
`default_nettype none
interface tsv_hdr_if;
	logic                          valid;
	logic                          ready;
	logic [tsv_pkg::TYPE_W-1:0]    hdr_type;
	logic [tsv_pkg::FLAGS_W-1:0]   seg_flags;
	logic [tsv_pkg::ID_W-1:0]      xfer_id;
	logic [tsv_pkg::SEGLEN_W-1:0]  seg_length;

	modport source (output valid, hdr_type, seg_flags, xfer_id, seg_length, input ready);
	modport sink   (input valid, hdr_type, seg_flags, xfer_id, seg_length, output ready);
endinterface

interface tsv_res_if;
	logic                          valid;
	logic                          ready;
	logic [tsv_pkg::STATUS_W-1:0]  status;
	logic [tsv_pkg::ID_W-1:0]      ack_id;
	logic [tsv_pkg::TOTAL_W-1:0]   ack_length;
	logic [tsv_pkg::TOTAL_W-1:0]   write_offset;

	modport source (output valid, status, ack_id, ack_length, write_offset, input ready);
	modport sink   (input valid, status, ack_id, ack_length, write_offset, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tsv_front.sv
// Front end: holds the MRU register and classifies each header on arrival.
// Depends on tsv_pkg.
`default_nettype none
module tsv_front #(
	parameter int MAX_SEGMENT_BYTES = 16777216
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [tsv_pkg::MRU_W-1:0]     cfg_wdata,
	input  wire [tsv_pkg::TYPE_W-1:0]    hdr_type,
	input  wire [tsv_pkg::FLAGS_W-1:0]   seg_flags,
	input  wire [tsv_pkg::ID_W-1:0]      xfer_id,
	input  wire [tsv_pkg::SEGLEN_W-1:0]  seg_length,
	output tsv_pkg::entry_t              ent
);

	localparam logic [tsv_pkg::SEGLEN_W-1:0] SEG_LIMIT =
		tsv_pkg::SEGLEN_W'(MAX_SEGMENT_BYTES);

	logic [tsv_pkg::MRU_W-1:0] mru_q;

	// negotiated MRU; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mru_q <= tsv_pkg::MRU_RESET;
		end else if (cfg_we) begin
			mru_q <= cfg_wdata;
		end
	end

	// classification
	always_comb begin
		case (hdr_type)
			tsv_pkg::MSG_DATA:      ent.cls = tsv_pkg::CLS_DATA;
			tsv_pkg::MSG_KEEPALIVE: ent.cls = tsv_pkg::CLS_KEEPALIVE;
			tsv_pkg::MSG_TERMINATE: ent.cls = tsv_pkg::CLS_TERMINATE;
			default:                ent.cls = tsv_pkg::CLS_BAD;
		endcase
		ent.start  = seg_flags[tsv_pkg::FLAG_START_BIT];
		ent.fin    = seg_flags[tsv_pkg::FLAG_END_BIT];
		ent.id     = xfer_id;
		ent.len    = seg_length[tsv_pkg::LEN_W-1:0];
		ent.gt_seg = seg_length > SEG_LIMIT;
		ent.gt_mru = seg_length > {{(tsv_pkg::SEGLEN_W-tsv_pkg::MRU_W){1'b0}}, mru_q};
	end

endmodule
`default_nettype wire

>>> rtl/core/tsv_queue.sv
// Short register queue of classified headers between front and back.
// Depends on tsv_pkg.
`default_nettype none
module tsv_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  tsv_pkg::entry_t  wr_ent,
	output logic             not_full,
	input  wire              pop,
	output logic             not_empty,
	output tsv_pkg::entry_t  rd_ent
);

	localparam int PTR_W = $clog2(tsv_pkg::QDEPTH);

	tsv_pkg::entry_t      mem_q [tsv_pkg::QDEPTH];
	logic [PTR_W-1:0]     wptr_q, rptr_q;
	logic [PTR_W:0]       count_q;

	assign not_full  = count_q != (PTR_W+1)'(tsv_pkg::QDEPTH);
	assign not_empty = count_q != '0;
	assign rd_ent    = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_ent;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(tsv_pkg::QDEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(tsv_pkg::QDEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/tsv_back.sv
// Back end: session and transfer state, segment checks and the result
// register. Depends on tsv_pkg.
`default_nettype none
module tsv_back #(
	parameter int MAX_TRANSFER_BYTES = 268435456
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           q_valid,
	input  tsv_pkg::entry_t               q_ent,
	output logic                          q_pop,
	output logic                          res_valid,
	input  wire                           res_ready,
	output logic [tsv_pkg::STATUS_W-1:0]  res_status,
	output logic [tsv_pkg::ID_W-1:0]      res_ack_id,
	output logic [tsv_pkg::TOTAL_W-1:0]   res_ack_length,
	output logic [tsv_pkg::TOTAL_W-1:0]   res_write_offset
);

	localparam int SUM_W = tsv_pkg::TOTAL_W + 1;
	localparam logic [SUM_W-1:0] XFER_LIMIT = SUM_W'(MAX_TRANSFER_BYTES);

	logic                         in_xfer_q;
	logic                         sess_up_q;
	logic [tsv_pkg::ID_W-1:0]     exp_id_q;
	logic [tsv_pkg::TOTAL_W-1:0]  total_q;
	logic                         out_valid_q;
	tsv_pkg::status_t             status_q;
	logic [tsv_pkg::ID_W-1:0]     ack_id_q;
	logic [tsv_pkg::TOTAL_W-1:0]  ack_len_q, offset_q;

	tsv_pkg::status_t             st;
	logic [SUM_W-1:0]             sum;
	logic                         go_idle, set_exp, end_sess;

	assign q_pop = q_valid && (!out_valid_q || res_ready);
	assign sum   = {1'b0, total_q} + {{(SUM_W-tsv_pkg::LEN_W){1'b0}}, q_ent.len};

	// checks, first failing wins
	always_comb begin
		st       = tsv_pkg::ST_ACCEPTED;
		go_idle  = 1'b0;
		set_exp  = 1'b0;
		end_sess = 1'b0;
		if (!sess_up_q) begin
			st = tsv_pkg::ST_NOT_CONN;
		end else begin
			case (q_ent.cls)
				tsv_pkg::CLS_TERMINATE: begin
					st       = tsv_pkg::ST_TERMINATED;
					end_sess = 1'b1;
					go_idle  = 1'b1;
				end
				tsv_pkg::CLS_KEEPALIVE: begin
					st = tsv_pkg::ST_KEEPALIVE;
				end
				tsv_pkg::CLS_DATA: begin
					if (!in_xfer_q) begin
						if (!q_ent.start) st = tsv_pkg::ST_NO_START;
						else set_exp = 1'b1;
					end else if (q_ent.start) begin
						st = tsv_pkg::ST_EXTRA_START;
					end else if (q_ent.id != exp_id_q) begin
						st = tsv_pkg::ST_ID_MISMATCH;
					end
					if (st == tsv_pkg::ST_ACCEPTED) begin
						if (q_ent.gt_seg) st = tsv_pkg::ST_SEG_LONG;
						else if (sum > XFER_LIMIT) st = tsv_pkg::ST_TOTAL_LONG;
						else if (q_ent.gt_mru) st = tsv_pkg::ST_SEG_LONG;
						else if (q_ent.fin) st = tsv_pkg::ST_COMPLETE;
					end
					go_idle = st != tsv_pkg::ST_ACCEPTED;
				end
				default: begin
					st      = tsv_pkg::ST_BAD_TYPE;
					go_idle = 1'b1;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_xfer_q   <= 1'b0;
			sess_up_q   <= 1'b1;
			exp_id_q    <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (set_exp) exp_id_q <= q_ent.id;
				if (end_sess) sess_up_q <= 1'b0;
				if (go_idle) begin
					in_xfer_q <= 1'b0;
					total_q   <= '0;
				end else if (st == tsv_pkg::ST_ACCEPTED && q_ent.cls == tsv_pkg::CLS_DATA
						&& sess_up_q) begin
					in_xfer_q <= 1'b1;
					total_q   <= sum[tsv_pkg::TOTAL_W-1:0];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_q <= st;
			ack_id_q <= (st == tsv_pkg::ST_COMPLETE)
				? (set_exp ? q_ent.id : exp_id_q) : '0;
			ack_len_q <= (st == tsv_pkg::ST_COMPLETE) ? sum[tsv_pkg::TOTAL_W-1:0] : '0;
			offset_q  <= (st == tsv_pkg::ST_COMPLETE || st == tsv_pkg::ST_ACCEPTED)
				? total_q : '0;
		end
	end

	assign res_valid        = out_valid_q;
	assign res_status       = status_q;
	assign res_ack_id       = ack_id_q;
	assign res_ack_length   = ack_len_q;
	assign res_write_offset = offset_q;

endmodule
`default_nettype wire

>>> rtl/core/transfer_segment_validator_top.sv
// Top level of the transfer segment validator: front classifier, queue and
// back end. Depends on tsv_pkg, tsv_if, tsv_front, tsv_queue, tsv_back.
//
//   channel   direction  transaction
//   hdr       in         hdr_type, seg_flags, xfer_id, seg_length
//   res       out        status, ack_id, ack_length, write_offset
//   cfg       in         cfg_we / cfg_wdata: negotiated segment MRU
//
// One header per cycle sustained while the result channel is not stalled; a
// header is written into the queue at acceptance, then the back-end check
// loads its result into the result register. The back end's state update
// is a combinational check fed back into its state registers.
// Reset leaves the queue empty, no transfer open and the session up.
// A stalled result holds the back end; the two-entry queue keeps taking
// headers until it fills.
`default_nettype none
module transfer_segment_validator_top #(
	parameter int MAX_SEGMENT_BYTES  = 16777216,
	parameter int MAX_TRANSFER_BYTES = 268435456
) (
	input  wire                       clk,
	input  wire                       arst_n,
	tsv_hdr_if.sink                   hdr,
	tsv_res_if.source                 res,
	input  wire                       cfg_we,
	input  wire [tsv_pkg::MRU_W-1:0]  cfg_wdata
);

	tsv_pkg::entry_t  f_ent, q_ent;
	logic             q_not_full, q_not_empty, q_pop;

	assign hdr.ready = q_not_full;

	tsv_front #(
		.MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.hdr_type   (hdr.hdr_type),
		.seg_flags  (hdr.seg_flags),
		.xfer_id    (hdr.xfer_id),
		.seg_length (hdr.seg_length),
		.ent        (f_ent)
	);

	tsv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (hdr.valid && q_not_full),
		.wr_ent    (f_ent),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_ent    (q_ent)
	);

	tsv_back #(
		.MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_not_empty),
		.q_ent            (q_ent),
		.q_pop            (q_pop),
		.res_valid        (res.valid),
		.res_ready        (res.ready),
		.res_status       (res.status),
		.res_ack_id       (res.ack_id),
		.res_ack_length   (res.ack_length),
		.res_write_offset (res.write_offset)
	);

endmodule
`default_nettype wire

>>> rtl/core/tsv_checker.sv
// Port-level checks on the validator's result channel, bound to the top.
// Depends on tsv_pkg and transfer_segment_validator_top.
`default_nettype none
module tsv_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           res_valid,
	input wire                           res_ready,
	input wire [tsv_pkg::STATUS_W-1:0]   res_status,
	input wire [tsv_pkg::ID_W-1:0]       res_ack_id,
	input wire [tsv_pkg::TOTAL_W-1:0]    res_ack_length,
	input wire [tsv_pkg::TOTAL_W-1:0]    res_write_offset
);

	logic term_seen_q;

	// a terminate has been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_seen_q <= 1'b0;
		end else if (res_valid && res_ready && res_status == tsv_pkg::ST_TERMINATED) begin
			term_seen_q <= 1'b1;
		end
	end

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_dead_session: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && term_seen_q |-> res_status == tsv_pkg::ST_NOT_CONN)
		else $error("result after terminate is not 'not connected'");

	a_ack_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != tsv_pkg::ST_COMPLETE
			|-> res_ack_id == '0 && res_ack_length == '0)
		else $error("acknowledge fields set without completion");

	a_offset_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != tsv_pkg::ST_COMPLETE
			&& res_status != tsv_pkg::ST_ACCEPTED |-> res_write_offset == '0)
		else $error("write offset set on a rejected transaction");

endmodule

bind transfer_segment_validator_top tsv_checker u_tsv_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_status       (res.status),
	.res_ack_id       (res.ack_id),
	.res_ack_length   (res.ack_length),
	.res_write_offset (res.write_offset)
);
`default_nettype wire
